### design/sfms_pkg.sv
// ----------------------------------------------------------------------------
// sfms_pkg
// Types, widths and codes shared by the substring first-match search block.
// ----------------------------------------------------------------------------
package sfms_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int WIN_IDX_W   = 4;
  localparam int POS_W       = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

  typedef enum logic [1:0] {
    STATUS_SEARCHING = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } search_status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              end_of_text;
  } sfms_item_t;

  typedef struct packed {
    logic       valid;
    sfms_item_t item;
  } sfms_head_t;

  typedef struct packed {
    logic [LEN_W-1:0]               pattern_length;
    logic [PATTERN_MAX*CHAR_W-1:0]  pattern_bytes;
  } sfms_cfg_t;

endpackage

### design/sfms_in_if.sv
// ----------------------------------------------------------------------------
// sfms_in_if
// Text character channel: valid, ready and one character or terminator item.
// ----------------------------------------------------------------------------
interface sfms_in_if import sfms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              end_of_text;

  modport source (output valid, text_char, end_of_text, input ready);
  modport sink   (input valid, text_char, end_of_text, output ready);
endinterface

### design/sfms_out_if.sv
// ----------------------------------------------------------------------------
// sfms_out_if
// Result channel: valid, ready and one search result item.
// ----------------------------------------------------------------------------
interface sfms_out_if import sfms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       search_status;
  logic [POS_W-1:0] match_index;
  logic             count_saturated;

  modport source (output valid, search_status, match_index, count_saturated, input ready);
  modport sink   (input valid, search_status, match_index, count_saturated, output ready);
endinterface

### design/sfms_front.sv
// ----------------------------------------------------------------------------
// sfms_front
// Accepts items, tags them as characters or terminators, and queues them.
// ----------------------------------------------------------------------------
module sfms_front import sfms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sfms_in_if.sink    in_ch,
  input  logic       pop,
  output sfms_head_t head
);

  sfms_item_t        q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              do_pop;

  assign in_ch.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r].text_char   <= in_ch.end_of_text ? '0 : in_ch.text_char;
      q_mem_r[wr_ptr_r].end_of_text <= in_ch.end_of_text;
    end
  end

endmodule

### design/sfms_back.sv
// ----------------------------------------------------------------------------
// sfms_back
// Shifts characters into the window, compares against the pattern in
// parallel and registers one result per item.
// ----------------------------------------------------------------------------
module sfms_back import sfms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sfms_cfg_t  cfg,
  input  sfms_head_t head,
  output logic       pop,
  sfms_out_if.source out_ch
);

  logic [CHAR_W-1:0] win_r   [PATTERN_MAX];
  logic [CHAR_W-1:0] win_nxt [PATTERN_MAX];
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic              reported_r, reported_nxt;
  logic              out_valid_r, out_valid_nxt;
  search_status_t    status_r, status_nxt;
  logic [POS_W-1:0]  index_r, index_nxt;
  logic              sat_r, sat_nxt;
  logic [LEN_W-1:0]  alen;
  logic              take;
  logic              is_end;
  logic              window_hit;
  logic [WIN_IDX_W-1:0] widx;

  assign take   = head.valid && (!out_valid_r || out_ch.ready);
  assign pop    = take;
  assign is_end = head.item.end_of_text;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.search_status   = status_r;
  assign out_ch.match_index     = index_r;
  assign out_ch.count_saturated = sat_r;

  always_comb begin
    alen = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                      : cfg.pattern_length;
    win_nxt[0] = is_end ? win_r[0] : head.item.text_char;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_nxt[i] = is_end ? win_r[i] : win_r[i-1];
    end
    pos_inc = (pos_r == '1) ? pos_r : pos_r + POS_W'(1);

    window_hit = 1'b1;
    widx       = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (LEN_W'(k) < alen) begin
        widx = WIN_IDX_W'(alen - LEN_W'(k) - LEN_W'(1));
        if (win_nxt[widx] != cfg.pattern_bytes[k*CHAR_W +: CHAR_W]) begin
          window_hit = 1'b0;
        end
      end
    end

    pos_nxt       = pos_r;
    reported_nxt  = reported_r;
    status_nxt    = status_r;
    index_nxt     = index_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (take) begin
      out_valid_nxt = 1'b1;
      status_nxt    = STATUS_SEARCHING;
      index_nxt     = '0;
      if (is_end) begin
        sat_nxt = (pos_r == '1);
        if (!reported_r) begin
          status_nxt = (alen == '0) ? STATUS_FOUND : STATUS_NOT_FOUND;
        end
        pos_nxt      = '0;
        reported_nxt = 1'b0;
      end else begin
        sat_nxt = (pos_inc == '1);
        pos_nxt = pos_inc;
        if (!reported_r) begin
          if (alen == '0) begin
            status_nxt   = STATUS_FOUND;
            reported_nxt = 1'b1;
          end else if (pos_inc >= POS_W'(alen) && window_hit) begin
            status_nxt   = STATUS_FOUND;
            index_nxt    = pos_inc - POS_W'(alen);
            reported_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    index_r  <= index_nxt;
    sat_r    <= sat_nxt;
    if (take) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

### design/substring_first_match_search.sv
// ----------------------------------------------------------------------------
// substring_first_match_search
// Streams text characters and reports the start index of the first
// occurrence of a configured pattern of up to sixteen bytes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  in_ch    input      valid / ready    text_char, end_of_text
//  out_ch   output     valid / ready    search_status, match_index, count_saturated
//  cfg_*    input      cfg_we           cfg_index, cfg_data
//
// One item is taken per cycle while the result side is not stalled. Its result
// is registered in the back end when the item is taken from the queue; the
// window compare in the back end is combinational.
// A four-item queue sits between the input and the compare stage, so input
// keeps flowing for four items while the result side is stalled.
// Reset is synchronous and active low and clears the pattern registers.
// ----------------------------------------------------------------------------
module substring_first_match_search import sfms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sfms_in_if.sink               in_ch,
  sfms_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]      pattern_length_r;
  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  sfms_cfg_t             cfg;
  sfms_head_t            head;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.pattern_length = pattern_length_r;
  assign cfg.pattern_bytes  = {pattern_high_r, pattern_low_r};

  sfms_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  sfms_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
